// ===== hw/rtl/glpf_pkg.sv =====
`default_nettype none
package glpf_pkg;

  // Default sizing
  localparam int MAX_COLS_DEF    = 32;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the channels
  localparam int PIX_W      = 32;
  localparam int ROW_OUT_W  = 10;
  localparam int COL_OUT_W  = 5;
  localparam int ROW_CNT_W  = 11;
  localparam int COL_CNT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = ROW_CNT_W'(2);
  localparam logic [COL_CNT_W-1:0] COL_COUNT_RST = COL_CNT_W'(2);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DRAIN
  } fsm_t;

  // Which neighbors of a cell exist
  typedef struct packed {
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } nbr_mask_t;

endpackage
`default_nettype wire

// ===== hw/rtl/glpf_in_if.sv =====
`default_nettype none
interface glpf_in_if;
  logic                     valid;
  logic                     ready;
  logic [glpf_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/glpf_out_if.sv =====
`default_nettype none
interface glpf_out_if;
  logic                         valid;
  logic                         ready;
  logic [glpf_pkg::ROW_OUT_W-1:0] peak_row;
  logic [glpf_pkg::COL_OUT_W-1:0] peak_col;
  logic                         last_of_run;

  modport source (output valid, output peak_row, output peak_col, output last_of_run,
                  input ready);
  modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/glpf_cfg_if.sv =====
`default_nettype none
interface glpf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [glpf_pkg::CFG_IDX_W-1:0]  index;
  logic [glpf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/grid_local_peak_finder_unit.sv =====
`default_nettype none
// 4-neighbor local maximum finder for a grid streamed in raster order.
//
// in_ch   : one grid value per item, row by row.
// out_ch  : row/column of each peak, in raster order; last_of_run marks the
//           final result caused by one input item.
// cfg_ch  : index 0 writes row_count, index 1 writes col_count; a write to
//           either restarts the grid at cell (0,0).
//
// Throughput: one item per cycle inside a grid while the receiver takes the
// results. Each item of a row r >= 1 decides the cell above it; the result
// is registered and visible in the cycle after the item is taken. The final
// cell of the grid starts a sweep of the last row over both read ports of the
// line store (flush, then drain), which takes no item and waits on stalls.
// Reset clears position, counts (both to 2) and the pipeline; the line store
// is not cleared, a row is read only after it has been written.
// A stalled receiver holds the output register; the input is not taken while
// a result waits and no room is free for the next one.
module grid_local_peak_finder_unit #(
  parameter int MAX_COLS    = glpf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = glpf_pkg::MAX_ROWS_DEF,
  parameter int VALUE_WIDTH = glpf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  glpf_in_if.sink   in_ch,
  glpf_out_if.source out_ch,
  glpf_cfg_if.sink  cfg_ch
);
  import glpf_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int DEPTH = 2 * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = VALUE_WIDTH;

  fsm_t                  state_r, state_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [ROW_CNT_W-1:0]  row_count_r, row_count_nxt;
  logic [COL_CNT_W-1:0]  col_count_r, col_count_nxt;
  logic [VW-1:0]         win_l_r, win_l_nxt;
  logic [VW-1:0]         win_m_r, win_m_nxt;
  logic [VW-1:0]         first_r, first_nxt;
  logic                  flush_slot_r, flush_slot_nxt;
  logic                  rd_ok_r;
  logic                  fwd_a_r, fwd_a_nxt;
  logic                  fwd_b_r, fwd_b_nxt;
  logic [VW-1:0]         fwd_data_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [ROW_OUT_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_OUT_W-1:0]  out_col_r, out_col_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [RW-1:0]         pend_row_r, pend_row_nxt;
  logic [CW-1:0]         pend_col_r, pend_col_nxt;

  logic [RW-1:0]         rows_last;
  logic [CW-1:0]         cols_last;
  logic [31:0]           rc32;
  logic [31:0]           cc32;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  out_free;
  logic [VW-1:0]         pix;
  logic                  cur_slot;
  logic                  at_last_col;
  logic                  final_item;
  logic                  ram_we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic [VW-1:0]         ram_a;
  logic [VW-1:0]         ram_b;
  logic [VW-1:0]         rd_a;
  logic [VW-1:0]         rd_b;
  logic [CW-1:0]         a_col;
  logic                  is_pk;
  nbr_mask_t             nbr;

  function automatic logic [AW-1:0] slot_addr(input logic slot, input logic [CW-1:0] col);
    logic [AW-1:0] base;
    base = slot ? AW'(MAX_COLS) : '0;
    return base + AW'(col);
  endfunction

  // Clamp the configured size to the supported range
  always_comb begin
    rc32 = 32'(row_count_r);
    cc32 = 32'(col_count_r);
    if (rc32 < 32'd2) begin
      rows_last = RW'(1);
    end else if (rc32 > 32'(MAX_ROWS)) begin
      rows_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_last = RW'(rc32 - 32'd1);
    end
    if (cc32 < 32'd2) begin
      cols_last = CW'(1);
    end else if (cc32 > 32'(MAX_COLS)) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(cc32 - 32'd1);
    end
  end

  assign pix         = in_ch.pixel_value[VW-1:0];
  assign cur_slot    = row_r[0];
  assign at_last_col = (col_r == cols_last);
  assign final_item  = at_last_col && (row_r == rows_last);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Handshakes
  assign cfg_ch.ready = (state_r == ST_RUN);
  assign in_ch.ready  = (state_r == ST_RUN) && rd_ok_r && out_free && !cfg_ch.valid;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.peak_row    = out_row_r;
  assign out_ch.peak_col    = out_col_r;
  assign out_ch.last_of_run = out_last_r;

  // Line store: two rows selected by row parity
  glpf_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (pix),
    .raddr_a (raddr_a),
    .rdata_a (ram_a),
    .raddr_b (raddr_b),
    .rdata_b (ram_b)
  );

  // Bypass a read that hit the entry written in the same cycle
  assign rd_a = fwd_a_r ? fwd_data_r : ram_a;
  assign rd_b = fwd_b_r ? fwd_data_r : ram_b;

  // Neighbor select: decide the cell above in run, the last row in flush
  always_comb begin
    if (state_r == ST_RUN) begin
      nbr.has_up    = (row_r > RW'(1));
      nbr.has_down  = 1'b1;
      nbr.has_left  = (col_r != '0);
      nbr.has_right = !at_last_col;
    end else begin
      nbr.has_up    = 1'b1;
      nbr.has_down  = 1'b0;
      nbr.has_left  = (k_r != '0);
      nbr.has_right = (k_r != cols_last);
    end
  end

  glpf_peak_check #(
    .VALUE_WIDTH (VW)
  ) u_peak_check (
    .self_val  ($signed(win_m_r)),
    .up_val    ($signed(rd_b)),
    .down_val  ($signed(pix)),
    .left_val  ($signed(win_l_r)),
    .right_val ($signed(rd_a)),
    .nbr       (nbr),
    .is_peak   (is_pk)
  );

  // Next state, store write and result generation
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    k_nxt          = k_r;
    row_count_nxt  = row_count_r;
    col_count_nxt  = col_count_r;
    win_l_nxt      = win_l_r;
    win_m_nxt      = win_m_r;
    first_nxt      = first_r;
    flush_slot_nxt = flush_slot_r;
    out_valid_nxt  = out_valid_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    ram_we         = 1'b0;
    waddr          = slot_addr(cur_slot, col_r);

    // Retire the output item once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // A write to row_count or col_count restarts the grid
    if (cfg_fire) begin
      priority if (cfg_ch.index == CFG_ROW_COUNT) begin
        row_count_nxt = cfg_ch.data[ROW_CNT_W-1:0];
        row_nxt       = '0;
        col_nxt       = '0;
      end else if (cfg_ch.index == CFG_COL_COUNT) begin
        col_count_nxt = cfg_ch.data[COL_CNT_W-1:0];
        row_nxt       = '0;
        col_nxt       = '0;
      end else begin
        row_nxt = row_r;
      end
    end

    unique case (state_r)
      ST_RUN: begin
        if (in_fire) begin
          ram_we    = 1'b1;
          if (col_r == '0) begin
            first_nxt = pix;
          end
          win_l_nxt = win_m_r;
          win_m_nxt = rd_a;
          if (final_item) begin
            // Hold the last decision until the sweep shows whether more follow
            state_nxt      = ST_FLUSH;
            k_nxt          = '0;
            flush_slot_nxt = cur_slot;
            win_m_nxt      = first_r;
            pend_valid_nxt = is_pk;
            pend_row_nxt   = row_r - RW'(1);
            pend_col_nxt   = col_r;
            row_nxt        = '0;
            col_nxt        = '0;
          end else begin
            if ((row_r != '0) && is_pk) begin
              out_valid_nxt = 1'b1;
              out_row_nxt   = ROW_OUT_W'(row_r - RW'(1));
              out_col_nxt   = COL_OUT_W'(col_r);
              out_last_nxt  = 1'b1;
            end
            if (at_last_col) begin
              col_nxt   = '0;
              row_nxt   = row_r + RW'(1);
              win_m_nxt = first_r;
            end else begin
              col_nxt = col_r + CW'(1);
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (is_pk) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_row_nxt   = ROW_OUT_W'(pend_row_r);
              out_col_nxt   = COL_OUT_W'(pend_col_r);
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_row_nxt   = rows_last;
            pend_col_nxt   = k_r;
          end
          win_l_nxt = win_m_r;
          win_m_nxt = rd_a;
          if (k_r == cols_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            k_nxt = k_r + CW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = ROW_OUT_W'(pend_row_r);
            out_col_nxt   = COL_OUT_W'(pend_col_r);
            out_last_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // Read addresses follow the next position so data lines up with it
  always_comb begin
    if (state_nxt == ST_FLUSH) begin
      a_col   = (k_nxt != cols_last) ? (k_nxt + CW'(1)) : k_nxt;
      raddr_a = slot_addr(flush_slot_nxt, a_col);
      raddr_b = slot_addr(!flush_slot_nxt, k_nxt);
    end else begin
      a_col   = (col_nxt != cols_last) ? (col_nxt + CW'(1)) : col_nxt;
      raddr_a = slot_addr(!row_nxt[0], a_col);
      raddr_b = slot_addr(row_nxt[0], col_nxt);
    end
  end

  assign fwd_a_nxt = ram_we && (waddr == raddr_a);
  assign fwd_b_nxt = ram_we && (waddr == raddr_b);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      row_r        <= '0;
      col_r        <= '0;
      k_r          <= '0;
      row_count_r  <= ROW_COUNT_RST;
      col_count_r  <= COL_COUNT_RST;
      rd_ok_r      <= 1'b0;
      fwd_a_r      <= 1'b0;
      fwd_b_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      k_r          <= k_nxt;
      row_count_r  <= row_count_nxt;
      col_count_r  <= col_count_nxt;
      rd_ok_r      <= 1'b1;
      fwd_a_r      <= fwd_a_nxt;
      fwd_b_r      <= fwd_b_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    win_l_r      <= win_l_nxt;
    win_m_r      <= win_m_nxt;
    first_r      <= first_nxt;
    flush_slot_r <= flush_slot_nxt;
    fwd_data_r   <= pix;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_last_r   <= out_last_nxt;
    pend_row_r   <= pend_row_nxt;
    pend_col_r   <= pend_col_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/glpf_ram.sv =====
`default_nettype none
module glpf_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two with registered data (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/glpf_peak_check.sv =====
`default_nettype none
module glpf_peak_check #(
  parameter int VALUE_WIDTH = glpf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic signed [VALUE_WIDTH-1:0] self_val,
  input  wire logic signed [VALUE_WIDTH-1:0] up_val,
  input  wire logic signed [VALUE_WIDTH-1:0] down_val,
  input  wire logic signed [VALUE_WIDTH-1:0] left_val,
  input  wire logic signed [VALUE_WIDTH-1:0] right_val,
  input  wire glpf_pkg::nbr_mask_t           nbr,
  output logic                               is_peak
);
  import glpf_pkg::*;

  // A cell loses only to an existing neighbor that is strictly greater
  always_comb begin
    is_peak = !(nbr.has_up    && (self_val < up_val))    &&
              !(nbr.has_down  && (self_val < down_val))  &&
              !(nbr.has_left  && (self_val < left_val))  &&
              !(nbr.has_right && (self_val < right_val));
  end

endmodule
`default_nettype wire

// ===== verif/glpf_peak_checker.sv =====
// Watches the three channels of the peak finder, tracks the grid position,
// the two stored rows and the configured size, and compares every peak
// result against the queue of peaks that the accepted pixels decide.
module glpf_peak_checker (
  input  logic clk,
  input  logic rst_n,
  glpf_in_if   in_mon,
  glpf_out_if  out_mon,
  glpf_cfg_if  cfg_mon,
  output int   mismatch_count,
  output int   peaks_pending
);
  import glpf_pkg::*;

  localparam int NCOLS = MAX_COLS_DEF;
  localparam int NROWS = MAX_ROWS_DEF;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } peak_rec_t;

  peak_rec_t               expected_peaks[$];
  logic signed [PIX_W-1:0] row_mem [2][NCOLS];
  logic [ROW_CNT_W-1:0]    row_count_reg;
  logic [COL_CNT_W-1:0]    col_count_reg;
  int                      next_row;
  int                      next_col;
  int                      miss_total;

  // Clamp the programmed size to the supported range
  function automatic int rows_in_use();
    int n;
    n = int'(row_count_reg);
    if (n < 2) n = 2;
    if (n > NROWS) n = NROWS;
    return n;
  endfunction

  function automatic int cols_in_use();
    int n;
    n = int'(col_count_reg);
    if (n < 2) n = 2;
    if (n > NCOLS) n = NCOLS;
    return n;
  endfunction

  // A cell wins when no existing neighbor is strictly greater
  function automatic logic wins_over_neighbors(input int slot, input int c, input int cols,
                                               input logic has_up,
                                               input logic signed [PIX_W-1:0] up,
                                               input logic has_down,
                                               input logic signed [PIX_W-1:0] down);
    logic signed [PIX_W-1:0] self;
    self = row_mem[slot][c];
    if (has_up && self < up) return 1'b0;
    if (has_down && self < down) return 1'b0;
    if (c > 0 && self < row_mem[slot][c-1]) return 1'b0;
    if (c + 1 < cols && self < row_mem[slot][c+1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_peak(input int r, input int c);
    peak_rec_t rec;
    rec.row  = ROW_OUT_W'(r);
    rec.col  = COL_OUT_W'(c);
    rec.last = 1'b0;
    expected_peaks.push_back(rec);
  endfunction

  // Store one pixel, decide the cell above it and, on the final cell,
  // sweep the whole last row
  task automatic predict_peaks(input logic [PIX_W-1:0] pixel);
    int                      rows;
    int                      cols;
    int                      r;
    int                      c;
    int                      cur;
    int                      prv;
    int                      k;
    int                      queued;
    logic signed [PIX_W-1:0] v;
    logic signed [PIX_W-1:0] up;
    peak_rec_t               tail;
    rows   = rows_in_use();
    cols   = cols_in_use();
    r      = next_row;
    c      = next_col;
    if (c >= cols) c = cols - 1;
    if (r >= rows) r = rows - 1;
    cur    = r & 1;
    prv    = cur ^ 1;
    v      = pixel;
    queued = expected_peaks.size();
    if (r >= 1) begin
      // this slot still holds row r-2 until the write below
      up = row_mem[cur][c];
      if (wins_over_neighbors(prv, c, cols, r >= 2, up, 1'b1, v)) add_peak(r - 1, c);
    end
    row_mem[cur][c] = v;
    if (r == rows - 1 && c == cols - 1) begin
      for (k = 0; k < cols; k++) begin
        up = row_mem[prv][k];
        if (wins_over_neighbors(cur, k, cols, 1'b1, up, 1'b0, '0)) add_peak(r, k);
      end
      next_row = 0;
      next_col = 0;
    end else begin
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
      end
      next_row = r;
      next_col = c;
    end
    // Mark the final result of this pixel
    if (expected_peaks.size() > queued) begin
      tail = expected_peaks.pop_back();
      tail.last = 1'b1;
      expected_peaks.push_back(tail);
    end
  endtask

  // Track config, predict on each pixel item, compare each result item
  always @(posedge clk) begin : watch
    peak_rec_t want;
    if (!rst_n) begin
      expected_peaks.delete();
      for (int s = 0; s < 2; s++)
        for (int k = 0; k < NCOLS; k++) row_mem[s][k] = '0;
      row_count_reg = ROW_COUNT_RST;
      col_count_reg = COL_COUNT_RST;
      next_row      = 0;
      next_col      = 0;
      miss_total    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_ROW_COUNT: begin
            row_count_reg = cfg_mon.data[ROW_CNT_W-1:0];
            next_row      = 0;
            next_col      = 0;
          end
          CFG_COL_COUNT: begin
            col_count_reg = cfg_mon.data[COL_CNT_W-1:0];
            next_row      = 0;
            next_col      = 0;
          end
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_peaks(in_mon.pixel_value);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_peaks.size() == 0) begin
          miss_total++;
          $display("%0t: unexpected peak: expected none, got row %0d col %0d last %0b",
                   $time, out_mon.peak_row, out_mon.peak_col, out_mon.last_of_run);
        end else begin
          want = expected_peaks.pop_front();
          if (want.row !== out_mon.peak_row || want.col !== out_mon.peak_col ||
              want.last !== out_mon.last_of_run) begin
            miss_total++;
            $display("%0t: peak mismatch: expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
                     $time, want.row, want.col, want.last,
                     out_mon.peak_row, out_mon.peak_col, out_mon.last_of_run);
          end
        end
      end
    end
    mismatch_count <= miss_total;
    peaks_pending  <= expected_peaks.size();
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import glpf_pkg::*;

  // Indexes past the register list: accepted, no effect
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam int RANDOM_PIXELS = 460;
  // Final-row sweep of the widest grid plus margin
  localparam int SETTLE_CYCLES = 2 * MAX_COLS_DEF + 16;

  typedef enum int {FILL_RANDOM, FILL_TIES, FILL_SIGNED_SMALL, FILL_EXTREMES, FILL_FLAT} fill_t;
  typedef enum int {RX_EAGER, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst_n;
  int       fail_total;
  int       pending_peaks;
  int       grid_rows = 2;
  int       grid_cols = 2;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_EAGER;
  int       rx_left = 0;

  glpf_in_if  in_ch ();
  glpf_out_if out_ch ();
  glpf_cfg_if cfg_ch ();

  grid_local_peak_finder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  glpf_peak_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (fail_total),
    .peaks_pending  (pending_peaks)
  );

  always #5 clk = ~clk;

  // Receiver: switch at random between stall patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_EAGER:  out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready <= ($urandom_range(0, 5) == 0);
      default:   out_ch.ready <= rx_left[3];
    endcase
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [PIX_W-1:0] pick_pixel(input fill_t fill,
                                                  input logic [PIX_W-1:0] flat);
    case (fill)
      FILL_TIES:         return PIX_W'($urandom_range(0, 3));
      FILL_SIGNED_SMALL: return PIX_W'($urandom_range(0, 4)) - PIX_W'(2);
      FILL_EXTREMES: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '1;
          3:       return '0;
          default: return $urandom;
        endcase
      end
      FILL_FLAT:         return flat;
      default:           return $urandom;
    endcase
  endfunction

  // Send one pixel item; open a new burst with a random gap when one runs out
  task automatic send_pixel(input logic [PIX_W-1:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rows(input int raw);
    write_reg(CFG_ROW_COUNT, CFG_DATA_W'(raw));
    grid_rows = (raw < 2) ? 2 : (raw > MAX_ROWS_DEF) ? MAX_ROWS_DEF : raw;
  endtask

  // Upper data bits are junk for the column register
  task automatic set_cols(input int raw, input int junk);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'({junk[4:0], raw[5:0]});
    write_reg(CFG_COL_COUNT, word);
    grid_cols = (raw[5:0] < 2) ? 2 : (raw[5:0] > MAX_COLS_DEF) ? MAX_COLS_DEF : raw[5:0];
  endtask

  // Hold off until every predicted peak has come out and the sweep is done
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_peaks != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_grid(input int count, input fill_t fill, input logic [PIX_W-1:0] flat,
                           input bit pause_inside);
    for (int i = 0; i < count; i++) begin
      // Go idle mid-grid; a spare index write must not restart the grid
      if (pause_inside && i == count / 2) begin
        wait_quiet();
        if ($urandom_range(0, 1) == 1)
          write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                    CFG_DATA_W'($urandom));
      end
      send_pixel(pick_pixel(fill, flat));
    end
  endtask

  initial begin : stimulus
    int    random_sent;
    int    phase;
    int    grids;
    int    cells;
    int    count;
    int    cut_max;
    int    rows_raw;
    int    cols_raw;
    bit    cut;
    fill_t fill;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.pixel_value = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_ROW_COUNT;
    cfg_ch.data       = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size 2x2: value extremes, then a flat plateau
    send_pixel(32'h8000_0000);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    repeat (4) send_pixel(32'h1234_5678);

    // Row count below range acts as 2; alternating bit patterns
    wait_quiet();
    set_rows(0);
    set_cols(3, 0);
    for (int i = 0; i < 6; i++) send_pixel((i % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555);

    // Both counts below range; last pixel decides no peak
    wait_quiet();
    set_rows(1);
    set_cols(0, 31);
    send_pixel(32'd4);
    send_pixel(32'd3);
    send_pixel(32'd3);
    send_pixel(32'd2);

    // Row count above range; leave the grid unfinished, next write restarts it
    wait_quiet();
    set_rows(2047);
    set_cols(2, 0);
    repeat (5) send_pixel($urandom);

    // Random phases of one or more grids
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_PIXELS) begin
      wait_quiet();
      case ($urandom_range(0, 9))
        0:       cols_raw = $urandom_range(0, 1);
        1:       cols_raw = 32;
        2:       cols_raw = $urandom_range(33, 63);
        3:       cols_raw = $urandom_range(7, 31);
        default: cols_raw = $urandom_range(2, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       rows_raw = $urandom_range(0, 1);
        1:       rows_raw = $urandom_range(1025, 2047);
        2:       rows_raw = MAX_ROWS_DEF;
        3:       rows_raw = $urandom_range(6, 12);
        default: rows_raw = $urandom_range(2, 5);
      endcase
      // Widest row, flat: the final pixel yields the most results
      if (phase == 0) begin
        cols_raw = 32;
        rows_raw = 2;
      end
      if ($urandom_range(0, 1) == 1) begin
        set_rows(rows_raw);
        set_cols(cols_raw, $urandom_range(0, 31));
      end else begin
        set_cols(cols_raw, $urandom_range(0, 31));
        set_rows(rows_raw);
      end
      grids = $urandom_range(1, 3);
      for (int g = 0; g < grids; g++) begin
        cells   = grid_rows * grid_cols;
        cut     = (cells > 256) || ($urandom_range(0, 7) == 0);
        cut_max = 3 * grid_cols + 2;
        if (cut_max > cells - 1) cut_max = cells - 1;
        count   = cut ? $urandom_range(1, cut_max) : cells;
        fill    = (phase == 0) ? FILL_FLAT : fill_t'($urandom_range(0, 4));
        send_grid(count, fill, $urandom, $urandom_range(0, 9) == 0);
        random_sent += count;
        // An unfinished grid is restarted by the next phase's writes
        if (cut) break;
      end
      phase++;
    end

    wait_quiet();
    @(negedge clk);
    if (fail_total == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/glpf_pkg.sv
hw/rtl/glpf_in_if.sv
hw/rtl/glpf_out_if.sv
hw/rtl/glpf_cfg_if.sv
hw/rtl/glpf_ram.sv
hw/rtl/glpf_peak_check.sv
hw/rtl/grid_local_peak_finder_unit.sv
verif/glpf_peak_checker.sv
verif/testbench.sv
